>>> src/bfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg
// shared types and constants of the button frame injector
// ----------------------------------------------------------------------------
package bfi_pkg;

    localparam int TICK_W   = 24;
    localparam int CODE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int BITS_W   = 5;
    localparam int PHASE_W  = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [CODE_W-1:0] CODE_INV_MASK = 8'hFF;
    localparam logic [BITS_W-1:0] FRAME_BITS    = 5'd16;

    localparam logic [REG_IDX_W-1:0] REG_SHORT_TICKS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_TICKS     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_CODE   = 2'd3;

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST    = 24'd200;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST     = 24'd800;
    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST = 24'd100000;
    localparam logic [CODE_W-1:0] RELEASE_CODE_RST   = 8'd0;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LOW      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd4;

    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] debounce_ticks;
        logic [CODE_W-1:0] release_code;
    } bfi_cfg_t;

endpackage

>>> src/bfi_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_cfg_regs
// apb register file holding the line timing and the release code
// ----------------------------------------------------------------------------
module bfi_cfg_regs import bfi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output bfi_cfg_t          cfg
);

    bfi_cfg_t                cfg_reg;
    logic                    wr_en;
    logic [REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks    <= SHORT_TICKS_RST;
            cfg_reg.long_ticks     <= LONG_TICKS_RST;
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.release_code   <= RELEASE_CODE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SHORT_TICKS:    cfg_reg.short_ticks    <= pwdata[TICK_W-1:0];
                REG_LONG_TICKS:     cfg_reg.long_ticks     <= pwdata[TICK_W-1:0];
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= pwdata[TICK_W-1:0];
                REG_RELEASE_CODE:   cfg_reg.release_code   <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SHORT_TICKS:    prdata = APB_DW'(cfg_reg.short_ticks);
            REG_LONG_TICKS:     prdata = APB_DW'(cfg_reg.long_ticks);
            REG_DEBOUNCE_TICKS: prdata = APB_DW'(cfg_reg.debounce_ticks);
            REG_RELEASE_CODE:   prdata = APB_DW'(cfg_reg.release_code);
            default:            prdata = '0;
        endcase
    end

endmodule

>>> src/button_frame_injector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_frame_injector
// keypad line pass-through that injects button frames toward the mainboard
//
// each s_ item is one time tick: the keypad level, a press request and a
// button code. each tick gives exactly one m_ item: the line level, the busy
// flag and a flag for a press dropped while busy.
// a press while idle sends a low start pulse, then the word {~code, code}
// msb first, each bit a high phase (long for 1, short for 0) and a short low
// phase. unless the code is the release code, the line is held high for the
// debounce time and a release frame follows.
// m_valid rises in the cycle after s_ accept; one item is taken every cycle
// while m_ready is high, set by the single state update between the input
// and the result register. while m_ready is low the result is held and
// s_ready stays high only while the result register is empty.
// reset sets the timing registers to 200, 800 and 100000 ticks, the release
// code to 0, the injector to idle and the result register to empty.
// ----------------------------------------------------------------------------
module button_frame_injector import bfi_pkg::*; #(
    parameter int TIMER_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_disp_level,
    input  logic              s_press,
    input  logic [CODE_W-1:0] s_button_code,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_main_line,
    output logic              m_busy_res,
    output logic              m_dropped
);

    localparam int LW = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
    localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;
    localparam logic [TIMER_BITS-1:0] TMR_ONE = TIMER_BITS'(1);

    bfi_cfg_t cfg;

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [BITS_W-1:0]     bits_left_reg, bits_left_next;
    logic [WORD_W-1:0]     frame_word_reg, frame_word_next;
    logic                  release_pending_reg, release_pending_next;

    logic                  m_valid_reg;
    logic                  m_main_line_reg, m_main_line_next;
    logic                  m_busy_res_reg, m_busy_res_next;
    logic                  m_dropped_reg, m_dropped_next;

    logic                  s_fire;
    logic [TIMER_BITS-1:0] ld_short, ld_long, ld_deb;
    logic [TIMER_BITS-1:0] timer_dec;
    logic [WORD_W-1:0]     word_shift;
    logic [BITS_W-1:0]     bits_dec;

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [TICK_W-1:0] v);
        logic [LW-1:0]         v_ext;
        logic [TIMER_BITS-1:0] t;
        v_ext = LW'(v);
        if (v_ext > LW'(TMR_MAX)) begin
            t = TMR_MAX;
        end else begin
            t = v_ext[TIMER_BITS-1:0];
        end
        if (t == '0) begin
            t = TMR_ONE;
        end
        return t;
    endfunction

    bfi_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign ld_short   = timer_load(cfg.short_ticks);
    assign ld_long    = timer_load(cfg.long_ticks);
    assign ld_deb     = timer_load(cfg.debounce_ticks);
    assign timer_dec  = timer_reg - TMR_ONE;
    assign word_shift = {frame_word_reg[WORD_W-2:0], 1'b0};
    assign bits_dec   = bits_left_reg - BITS_W'(1);

    always_comb begin
        phase_next           = phase_reg;
        timer_next           = timer_reg;
        bits_left_next       = bits_left_reg;
        frame_word_next      = frame_word_reg;
        release_pending_next = release_pending_reg;
        m_dropped_next       = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (s_press) begin
                release_pending_next = (s_button_code != cfg.release_code);
                frame_word_next      = {s_button_code ^ CODE_INV_MASK, s_button_code};
                bits_left_next       = FRAME_BITS;
                phase_next           = PH_START;
                timer_next           = ld_short;
            end
        end else begin
            m_dropped_next = s_press;
            timer_next     = timer_dec;
            if (timer_dec == '0) begin
                unique case (phase_reg)
                    PH_START: begin
                        phase_next = PH_HIGH;
                        timer_next = frame_word_reg[WORD_W-1] ? ld_long : ld_short;
                    end
                    PH_HIGH: begin
                        phase_next = PH_LOW;
                        timer_next = ld_short;
                    end
                    PH_LOW: begin
                        frame_word_next = word_shift;
                        bits_left_next  = bits_dec;
                        if (bits_dec != '0) begin
                            phase_next = PH_HIGH;
                            timer_next = word_shift[WORD_W-1] ? ld_long : ld_short;
                        end else if (release_pending_reg) begin
                            phase_next = PH_DEBOUNCE;
                            timer_next = ld_deb;
                        end else begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                        end
                    end
                    PH_DEBOUNCE: begin
                        release_pending_next = 1'b0;
                        frame_word_next      = {cfg.release_code ^ CODE_INV_MASK,
                                                cfg.release_code};
                        bits_left_next       = FRAME_BITS;
                        phase_next           = PH_START;
                        timer_next           = ld_short;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                    end
                endcase
            end
        end

        unique case (phase_next)
            PH_IDLE:     m_main_line_next = s_disp_level;
            PH_HIGH:     m_main_line_next = 1'b1;
            PH_DEBOUNCE: m_main_line_next = 1'b1;
            default:     m_main_line_next = 1'b0;
        endcase
        m_busy_res_next = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            timer_reg           <= '0;
            bits_left_reg       <= '0;
            frame_word_reg      <= '0;
            release_pending_reg <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg           <= phase_next;
                timer_reg           <= timer_next;
                bits_left_reg       <= bits_left_next;
                frame_word_reg      <= frame_word_next;
                release_pending_reg <= release_pending_next;
                m_valid_reg         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_main_line_reg <= m_main_line_next;
            m_busy_res_reg  <= m_busy_res_next;
            m_dropped_reg   <= m_dropped_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_main_line = m_main_line_reg;
    assign m_busy_res  = m_busy_res_reg;
    assign m_dropped   = m_dropped_reg;

    // busy result tracks the phase left by the item
    a_busy_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (m_busy_res == (phase_reg != PH_IDLE)))
        else $error("busy flag does not match phase");

    a_timer_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (timer_reg != '0))
        else $error("phase timer empty while injecting");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (bits_left_reg <= FRAME_BITS))
        else $error("bit count out of range");

    a_idle_no_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> !release_pending_reg)
        else $error("release pending while idle");

endmodule

>>> bench/tb_button_frame_injector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_frame_injector
// self-checking bench for the button frame injector
//
// ticks go in on the s_ channel and every tick gives one m_ item, checked
// against a tick-level model of the injector kept inside the bench. a short
// table covers reset values, extreme and zero timings, the release code and
// presses while busy; random phases with small timings follow, with gaps and
// stalls on both channels, one long receiver hold-off and one sender pause.
// register writes happen only with the injector idle and are read back.
// ----------------------------------------------------------------------------
module tb_button_frame_injector;
    import bfi_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DIR_N       = 33;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic line;
        logic busy;
        logic drop;
    } line_res_t;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [APB_DW-1:0]      val;
        logic                   lvl;
        logic                   prs;
        logic [CODE_W-1:0]      code;
        logic                   typed;
        line_res_t              want;
    } dir_row_t;

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic              s_disp_level;
    logic              s_press;
    logic [CODE_W-1:0] s_button_code;
    logic              m_valid;
    logic              m_ready;
    logic              m_main_line;
    logic              m_busy_res;
    logic              m_dropped;

    // injector model state and its copy of the registers
    logic [PHASE_W-1:0] inj_phase;
    logic [TICK_W-1:0]  inj_timer;
    logic [BITS_W-1:0]  inj_bits;
    logic [WORD_W-1:0]  inj_word;
    logic               inj_rel_pending;
    logic [TICK_W-1:0]  cfg_short;
    logic [TICK_W-1:0]  cfg_long;
    logic [TICK_W-1:0]  cfg_debounce;
    logic [CODE_W-1:0]  cfg_release;

    line_res_t offered_q[$];
    line_res_t line_exp_q[$];

    int err_cnt     = 0;
    int n_checked   = 0;
    int n_ticks     = 0;
    int n_writes    = 0;
    int frames_sent = 0;
    int drops_seen  = 0;
    int cyc         = 0;
    int hold_cycles = 0;
    bit no_idle     = 1'b0;

    dir_row_t dir_rows [0:DIR_N-1] = '{
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b0, 8'h00, 1'b1, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b0, 8'h00, 1'b1, 3'b100},
        '{ROW_REG,  REG_SHORT_TICKS,    32'h00FF_FFFF, 1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_LONG_TICKS,     32'h00FF_FFFF, 1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 32'h00FF_FFFF, 1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b0, 8'hFF, 1'b1, 3'b100},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b0, 8'hFF, 1'b1, 3'b000},
        '{ROW_REG,  REG_SHORT_TICKS,    32'd1,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_LONG_TICKS,     32'd2,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_RELEASE_CODE,   32'hFF,        1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'hFF, 1'b1, 3'b010},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b1, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b0, 8'h5A, 1'b0, 3'b000},
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 32'd2,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_RELEASE_CODE,   32'h00,        1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'h00, 1'b1, 3'b010},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'hA5, 1'b0, 3'b000},
        '{ROW_REG,  REG_SHORT_TICKS,    32'd0,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_LONG_TICKS,     32'd0,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 32'd0,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b1, 8'hFF, 1'b1, 3'b010},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'h81, 1'b0, 3'b000},
        '{ROW_REG,  REG_SHORT_TICKS,    32'd3,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_LONG_TICKS,     32'd1,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'hA5, 1'b1, 3'b010},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b1, 8'h5A, 1'b0, 3'b000},
        '{ROW_REG,  REG_DEBOUNCE_TICKS, 32'd5,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_REG,  REG_RELEASE_CODE,   32'h3C,        1'b0, 1'b0, 8'h00, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'h3C, 1'b1, 3'b010},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b1, 1'b1, 8'hC3, 1'b0, 3'b000},
        '{ROW_TICK, REG_SHORT_TICKS,    32'd0,         1'b0, 1'b0, 8'h00, 1'b0, 3'b000}
    };

    button_frame_injector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_disp_level  (s_disp_level),
        .s_press       (s_press),
        .s_button_code (s_button_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_main_line   (m_main_line),
        .m_busy_res    (m_busy_res),
        .m_dropped     (m_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void note_err(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("error: %s", msg);
        end
    endfunction

    function automatic logic [TICK_W-1:0] ticks_or_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic void open_frame(input logic [CODE_W-1:0] code);
        inj_word  = {code ^ CODE_INV_MASK, code};
        inj_bits  = FRAME_BITS;
        inj_phase = PH_START;
        inj_timer = ticks_or_one(cfg_short);
        frames_sent++;
    endfunction

    function automatic void open_high();
        inj_phase = PH_HIGH;
        inj_timer = ticks_or_one(inj_word[WORD_W-1] ? cfg_long : cfg_short);
    endfunction

    function automatic line_res_t predict_tick(input logic lvl, input logic prs,
                                               input logic [CODE_W-1:0] code);
        line_res_t r;
        r.drop = 1'b0;
        if (inj_phase == PH_IDLE) begin
            if (prs) begin
                inj_rel_pending = (code != cfg_release);
                open_frame(code);
            end
        end else begin
            r.drop    = prs;
            inj_timer = inj_timer - TICK_W'(1);
            if (inj_timer == '0) begin
                case (inj_phase)
                    PH_START: open_high();
                    PH_HIGH: begin
                        inj_phase = PH_LOW;
                        inj_timer = ticks_or_one(cfg_short);
                    end
                    PH_LOW: begin
                        inj_word = inj_word << 1;
                        inj_bits = inj_bits - BITS_W'(1);
                        if (inj_bits != '0) begin
                            open_high();
                        end else if (inj_rel_pending) begin
                            inj_phase = PH_DEBOUNCE;
                            inj_timer = ticks_or_one(cfg_debounce);
                        end else begin
                            inj_phase = PH_IDLE;
                            inj_timer = '0;
                        end
                    end
                    PH_DEBOUNCE: begin
                        inj_rel_pending = 1'b0;
                        open_frame(cfg_release);
                    end
                    default: begin
                        inj_phase = PH_IDLE;
                        inj_timer = '0;
                    end
                endcase
            end
        end
        case (inj_phase)
            PH_IDLE:              r.line = lvl;
            PH_HIGH, PH_DEBOUNCE: r.line = 1'b1;
            default:              r.line = 1'b0;
        endcase
        r.busy = (inj_phase != PH_IDLE);
        drops_seen += r.drop;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // offers one tick and returns at the edge where it is taken
    task automatic push_tick(input logic lvl, input logic prs, input logic [CODE_W-1:0] code,
                             input logic typed, input line_res_t want);
        line_res_t calc;
        calc = predict_tick(lvl, prs, code);
        offered_q.push_back(typed ? want : calc);
        n_ticks++;
        s_valid       <= 1'b1;
        s_disp_level  <= lvl;
        s_press       <= prs;
        s_button_code <= code;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic idle_gap(input int g);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (offered_q.size() != 0 || line_exp_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // run the injector back to idle with plain ticks before touching registers
    task automatic settle_idle();
        while (inj_phase != PH_IDLE) begin
            push_tick(1'($urandom_range(0, 1)), 1'b0, CODE_W'($urandom_range(0, 255)),
                      1'b0, '0);
        end
        wait_drained();
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] mask;
        mask = (idx == REG_RELEASE_CODE) ? APB_DW'({CODE_W{1'b1}}) : APB_DW'({TICK_W{1'b1}});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_SHORT_TICKS:    cfg_short    = val[TICK_W-1:0];
            REG_LONG_TICKS:     cfg_long     = val[TICK_W-1:0];
            REG_DEBOUNCE_TICKS: cfg_debounce = val[TICK_W-1:0];
            REG_RELEASE_CODE:   cfg_release  = val[CODE_W-1:0];
            default: ;
        endcase
        n_writes++;
        // read back straight after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if ((prdata & mask) !== (val & mask)) begin
            note_err($sformatf("register %0d read back %0h, expected %0h",
                               idx, prdata & mask, val & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin : line_check
        line_res_t got;
        line_res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_main_line, m_busy_res, m_dropped};
                n_checked++;
                if (line_exp_q.size() == 0) begin
                    note_err($sformatf("result with nothing expected: line %b busy %b drop %b",
                                       got.line, got.busy, got.drop));
                end else begin
                    want = line_exp_q.pop_front();
                    if (got.line !== want.line || got.busy !== want.busy
                            || got.drop !== want.drop) begin
                        note_err($sformatf(
                            "result %0d: expected line %b busy %b drop %b, got %b %b %b",
                            n_checked, want.line, want.busy, want.drop,
                            got.line, got.busy, got.drop));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (offered_q.size() == 0) begin
                    note_err("item taken with nothing offered");
                end else begin
                    line_exp_q.push_back(offered_q.pop_front());
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("button_frame_injector regression: fail");
            $finish;
        end
    end

    initial begin : sink
        int g;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                while (hold_cycles > 0) begin
                    @(posedge aclk);
                    hold_cycles--;
                end
                m_ready <= 1'b1;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin : stim
        int k;
        int p;
        int n;
        int rate [RAND_PHASES] = '{2, 10, 25, 50, 6};
        logic prs;
        logic [CODE_W-1:0] code;

        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_disp_level  = 1'b0;
        s_press       = 1'b0;
        s_button_code = '0;
        inj_phase       = PH_IDLE;
        inj_timer       = '0;
        inj_bits        = '0;
        inj_word        = '0;
        inj_rel_pending = 1'b0;
        cfg_short       = SHORT_TICKS_RST;
        cfg_long        = LONG_TICKS_RST;
        cfg_debounce    = DEBOUNCE_TICKS_RST;
        cfg_release     = RELEASE_CODE_RST;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIR_N; k++) begin
            if (dir_rows[k].kind == ROW_REG) begin
                settle_idle();
                reg_write(dir_rows[k].idx, dir_rows[k].val);
            end else begin
                push_tick(dir_rows[k].lvl, dir_rows[k].prs, dir_rows[k].code,
                          dir_rows[k].typed, dir_rows[k].want);
                idle_gap(pick_gap());
            end
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            settle_idle();
            reg_write(REG_SHORT_TICKS, $urandom_range(0, 3));
            reg_write(REG_LONG_TICKS, $urandom_range(0, 6));
            reg_write(REG_DEBOUNCE_TICKS, $urandom_range(0, 24));
            reg_write(REG_RELEASE_CODE, $urandom_range(0, 255));
            no_idle = (p == RAND_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while items keep coming
                if (p == 1 && n == 20) begin
                    hold_cycles = 300;
                end
                if (p == 3 && n == 30) begin
                    wait_drained();
                end
                prs  = ($urandom_range(0, 99) < rate[p]);
                code = ($urandom_range(0, 3) == 0) ? cfg_release
                                                   : CODE_W'($urandom_range(0, 255));
                push_tick(1'($urandom_range(0, 1)), prs, code, 1'b0, '0);
                idle_gap(pick_gap());
            end
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("ran %0d ticks under %0d register writes: %0d frames, %0d presses dropped",
                 n_ticks, n_writes, frames_sent, drops_seen);
        $display("checked %0d results, %0d mismatches", n_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("button_frame_injector regression: pass");
        end else begin
            $display("button_frame_injector regression: fail");
        end
        $finish;
    end

endmodule
